### hw/rtl/safs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package safs_pkg;

  localparam int SLOT_W            = 8;
  localparam int OP_W              = 2;
  localparam int DEF_CAPACITY      = 256;
  localparam int DEF_ENTRY_WIDTH   = 64;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic finish;   // result loads into the output register this cycle
  } safs_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/slot_allocator_free_stack.sv
// An accepted beat first does its free-stack or entry-memory read; in WAIT it
// writes back and loads the result, stalling while the output register still
// holds an unread one. A new item is accepted only after the last has finished.
// A finished result may wait in the output register while the next item starts.
// Reset (rst_n low, synchronous) clears the free-stack depth and the high-water
// count; the memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module slot_allocator_free_stack
  import safs_pkg::*;
#(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [OP_W-1:0]        in_operation,
  input  wire logic [SLOT_W-1:0]      in_slot_in,
  input  wire logic [ENTRY_WIDTH-1:0] in_entry_in,
  input  wire logic                   in_return_copy,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_status,
  output logic [SLOT_W-1:0]           out_slot_out,
  output logic [ENTRY_WIDTH-1:0]      out_entry_out,
  output logic                        out_entry_valid
);

  safs_cmd_t cmd;

  safs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  safs_dp #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_slot_in      (in_slot_in),
    .in_entry_in     (in_entry_in),
    .in_return_copy  (in_return_copy),
    .out_status      (out_status),
    .out_slot_out    (out_slot_out),
    .out_entry_out   (out_entry_out),
    .out_entry_valid (out_entry_valid)
  );

endmodule

`default_nettype wire

### hw/rtl/safs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module safs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/safs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module safs_ctrl
  import safs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output safs_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.accept = in_valid && (state_r == S_IDLE);
  // The memory read of the item is ready in WAIT; it completes once the
  // output register is free or is being emptied.
  assign cmd.finish = (state_r == S_WAIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/safs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module safs_dp
  import safs_pkg::*;
#(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire safs_cmd_t              cmd,
  input  wire logic [OP_W-1:0]        in_operation,
  input  wire logic [SLOT_W-1:0]      in_slot_in,
  input  wire logic [ENTRY_WIDTH-1:0] in_entry_in,
  input  wire logic                   in_return_copy,
  output logic                        out_status,
  output logic [SLOT_W-1:0]           out_slot_out,
  output logic [ENTRY_WIDTH-1:0]      out_entry_out,
  output logic                        out_entry_valid
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [CNT_W-1:0] free_depth_r, free_depth_nxt;
  logic [CNT_W-1:0] high_water_r, high_water_nxt;

  // Per-item state held from acceptance to completion.
  logic                   pop_r;
  logic                   write_r;
  logic                   full_r;
  logic                   rdv_r;
  logic [IDX_W-1:0]       target_r;
  logic [ENTRY_WIDTH-1:0] entry_r;

  logic [CMP_W-1:0] slot_ext;
  logic [CMP_W-1:0] hw_ext;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;
  logic             slot_used;
  logic             slot_top;

  logic             is_add, is_read, is_remove;
  logic             can_pop, can_grow;

  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_waddr, stk_raddr;
  logic [IDX_W-1:0] stk_rdata;

  logic                   ent_we, ent_re;
  logic [IDX_W-1:0]       ent_waddr;
  logic [ENTRY_WIDTH-1:0] ent_rdata;
  logic [IDX_W-1:0]       wr_target;

  assign slot_ext  = CMP_W'(in_slot_in);
  assign hw_ext    = CMP_W'(high_water_r);
  assign slot_idx  = IDX_W'(slot_ext);
  assign slot_ok   = slot_ext < CAP_CMP;
  assign slot_used = slot_ext < hw_ext;
  assign slot_top  = (slot_ext + CMP_W'(1)) == hw_ext;

  assign is_add    = cmd.accept && (in_operation == OP_ADD);
  assign is_read   = cmd.accept && (in_operation == OP_READ);
  assign is_remove = cmd.accept && (in_operation == OP_REMOVE) && slot_used;
  assign can_pop   = free_depth_r != '0;
  assign can_grow  = high_water_r < CAP_CNT;

  // Free stack: a remove of a used slot below the top pushes, an add pops.
  assign stk_we    = is_remove && !slot_top && (free_depth_r < CAP_CNT);
  assign stk_waddr = IDX_W'(free_depth_r);
  assign stk_re    = is_add && can_pop;
  assign stk_raddr = IDX_W'(free_depth_r - ONE_CNT);

  assign ent_re    = (is_read && slot_ok) || (is_remove && in_return_copy);
  assign wr_target = pop_r ? stk_rdata : target_r;
  assign ent_we    = cmd.finish && write_r;
  assign ent_waddr = wr_target;

  always_comb begin
    free_depth_nxt = free_depth_r;
    high_water_nxt = high_water_r;
    if (is_add) begin
      if (can_pop) begin
        free_depth_nxt = free_depth_r - ONE_CNT;
      end else if (can_grow) begin
        high_water_nxt = high_water_r + ONE_CNT;
      end
    end else if (is_remove) begin
      if (slot_top) begin
        high_water_nxt = high_water_r - ONE_CNT;
      end else if (stk_we) begin
        free_depth_nxt = free_depth_r + ONE_CNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_depth_r <= '0;
      high_water_r <= '0;
    end else begin
      free_depth_r <= free_depth_nxt;
      high_water_r <= high_water_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pop_r    <= is_add && can_pop;
      write_r  <= is_add && (can_pop || can_grow);
      full_r   <= is_add && !can_pop && !can_grow;
      rdv_r    <= ent_re;
      target_r <= IDX_W'(high_water_r);
      entry_r  <= in_entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status      <= full_r;
      out_slot_out    <= write_r ? SLOT_W'(wr_target) : '0;
      out_entry_out   <= rdv_r ? ent_rdata : '0;
      out_entry_valid <= rdv_r;
    end
  end

  safs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (slot_idx),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  safs_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (entry_r),
    .re    (ent_re),
    .raddr (slot_idx),
    .rdata (ent_rdata)
  );

endmodule

`default_nettype wire

### dv/tb_slot_allocator_free_stack.sv
`timescale 1ns / 1ps

module tb_slot_allocator_free_stack;
  import safs_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int EW = DEF_ENTRY_WIDTH;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_FULL = 1'b1;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic status;
    logic [SLOT_W-1:0] slot;
    logic [EW-1:0] entry;
    logic entry_valid;
  } result_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] slot;
    logic [EW-1:0] entry;
    logic rc;
    bit known;
    result_t want;
  } stim_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] in_operation;
  logic [SLOT_W-1:0] in_slot_in;
  logic [EW-1:0] in_entry_in;
  logic in_return_copy;
  logic out_valid;
  logic out_ready;
  logic out_status;
  logic [SLOT_W-1:0] out_slot_out;
  logic [EW-1:0] out_entry_out;
  logic out_entry_valid;

  // Shadow copy of the allocator state.
  logic [EW-1:0] store_mem [CAP];
  logic [SLOT_W-1:0] free_slots [CAP];
  bit written_slot [CAP];
  int free_cnt;
  int top_cnt;

  result_t pending_results[$];
  result_t seen_want;
  stim_t dir_rows[$];
  int mismatch_count;
  int items_sent;
  int quiet_cycles;
  bit calm;

  slot_allocator_free_stack #(
    .CAPACITY(CAP),
    .ENTRY_WIDTH(EW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_slot_in(in_slot_in),
    .in_entry_in(in_entry_in),
    .in_return_copy(in_return_copy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_slot_out(out_slot_out),
    .out_entry_out(out_entry_out),
    .out_entry_valid(out_entry_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t res(input logic st, input logic [SLOT_W-1:0] sl,
                                  input logic [EW-1:0] en, input logic ev);
    result_t r;
    r.status = st;
    r.slot = sl;
    r.entry = en;
    r.entry_valid = ev;
    return r;
  endfunction

  function automatic stim_t row(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sl,
                                input logic [EW-1:0] en, input logic rc,
                                input bit known, input result_t want);
    stim_t s;
    s.op = op;
    s.slot = sl;
    s.entry = en;
    s.rc = rc;
    s.known = known;
    s.want = want;
    return s;
  endfunction

  // Applies one operation to the shadow state and returns the result it should give.
  function automatic result_t apply_slot_op(input logic [OP_W-1:0] op,
                                            input logic [SLOT_W-1:0] sl,
                                            input logic [EW-1:0] en, input logic rc);
    result_t r;
    int tgt;
    bit have;
    r = '0;
    case (op)
      OP_ADD: begin
        have = 1'b1;
        tgt = 0;
        if (free_cnt > 0) begin
          free_cnt--;
          tgt = int'(free_slots[free_cnt]);
        end else if (top_cnt < CAP) begin
          tgt = top_cnt;
          top_cnt++;
        end else begin
          have = 1'b0;
        end
        if (have) begin
          store_mem[tgt] = en;
          written_slot[tgt] = 1'b1;
          r.slot = tgt[SLOT_W-1:0];
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_READ: begin
        r.entry = store_mem[sl];
        r.entry_valid = 1'b1;
      end
      OP_REMOVE: begin
        if (int'(sl) < top_cnt) begin
          if (rc) begin
            r.entry = store_mem[sl];
            r.entry_valid = 1'b1;
          end
          if (int'(sl) == top_cnt - 1) begin
            top_cnt--;
          end else if (free_cnt < CAP) begin
            free_slots[free_cnt] = sl;
            free_cnt++;
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sl,
                         input logic [EW-1:0] en, input logic rc,
                         input bit known, input result_t want);
    int gap;
    result_t r;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_slot_in <= sl;
    in_entry_in <= en;
    in_return_copy <= rc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_slot_op(op, sl, en, rc);
    pending_results.push_back(known ? want : r);
    items_sent++;
    if (items_sent % 32 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_random(input int add_pct, input int read_pct, input int remove_pct);
    int pick;
    int start;
    bit found;
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] sl;
    logic [EW-1:0] en;
    logic rc;
    pick = $urandom_range(0, 99);
    sl = SLOT_W'($urandom);
    rc = 1'($urandom);
    case ($urandom_range(0, 9))
      0: en = '1;
      1: en = '0;
      2: en = 64'd1 << $urandom_range(0, EW - 1);
      default: en = {$urandom, $urandom};
    endcase
    if (pick < add_pct) begin
      op = OP_ADD;
    end else if (pick < add_pct + read_pct) begin
      // Reads only ever target slots that an add has already filled.
      op = OP_READ;
      found = 1'b0;
      start = $urandom_range(0, CAP - 1);
      for (int i = 0; i < CAP; i++) begin
        if (!found && written_slot[(start + i) % CAP]) begin
          found = 1'b1;
          sl = SLOT_W'((start + i) % CAP);
        end
      end
      if (!found) op = OP_ADD;
    end else if (pick < add_pct + read_pct + remove_pct) begin
      op = OP_REMOVE;
      if (top_cnt > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          sl = SLOT_W'(top_cnt - 1);
        end else begin
          sl = SLOT_W'($urandom_range(0, top_cnt - 1));
        end
      end
    end else begin
      // Noise: the unused code, or a remove of any slot, mostly not in use.
      op = $urandom_range(0, 1) ? OP_UNUSED : OP_REMOVE;
    end
    send_op(op, sl, en, rc, 1'b0, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_ADD;
    in_slot_in = '0;
    in_entry_in = '0;
    in_return_copy = 1'b0;
    free_cnt = 0;
    top_cnt = 0;
    mismatch_count = 0;
    items_sent = 0;
    calm = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      store_mem[i] = '0;
      free_slots[i] = '0;
      written_slot[i] = 1'b0;
    end

    dir_rows.push_back(row(OP_ADD, 8'd0, '1, 1'b0, 1'b1, res(ST_OK, 8'd0, '0, 1'b0)));
    dir_rows.push_back(row(OP_ADD, 8'd0, '0, 1'b0, 1'b1, res(ST_OK, 8'd1, '0, 1'b0)));
    dir_rows.push_back(row(OP_ADD, 8'd0, 64'hA5A5_5A5A_F00D_1234, 1'b0, 1'b1,
                           res(ST_OK, 8'd2, '0, 1'b0)));
    dir_rows.push_back(row(OP_ADD, 8'd0, 64'h8000_0000_0000_0001, 1'b0, 1'b1,
                           res(ST_OK, 8'd3, '0, 1'b0)));
    dir_rows.push_back(row(OP_READ, 8'd0, '0, 1'b0, 1'b1, res(ST_OK, 8'd0, '1, 1'b1)));
    dir_rows.push_back(row(OP_READ, 8'd1, '1, 1'b1, 1'b1, res(ST_OK, 8'd0, '0, 1'b1)));
    // Slot 255 is not in use, so the remove is ignored.
    dir_rows.push_back(row(OP_REMOVE, 8'd255, '1, 1'b1, 1'b1, res(ST_OK, 8'd0, '0, 1'b0)));
    dir_rows.push_back(row(OP_REMOVE, 8'd1, '0, 1'b1, 1'b1, res(ST_OK, 8'd0, '0, 1'b1)));
    dir_rows.push_back(row(OP_REMOVE, 8'd0, '0, 1'b0, 1'b1, res(ST_OK, 8'd0, '0, 1'b0)));
    // The free stack hands back the last freed slot first.
    dir_rows.push_back(row(OP_ADD, 8'd0, 64'd1, 1'b0, 1'b1, res(ST_OK, 8'd0, '0, 1'b0)));
    dir_rows.push_back(row(OP_ADD, 8'd0, 64'd2, 1'b0, 1'b1, res(ST_OK, 8'd1, '0, 1'b0)));
    dir_rows.push_back(row(OP_REMOVE, 8'd3, '0, 1'b1, 1'b1,
                           res(ST_OK, 8'd0, 64'h8000_0000_0000_0001, 1'b1)));
    dir_rows.push_back(row(OP_ADD, 8'd0, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(OP_UNUSED, 8'd255, '1, 1'b1, 1'b1, res(ST_OK, 8'd0, '0, 1'b0)));
    dir_rows.push_back(row(OP_REMOVE, 8'd1, '0, 1'b1, 1'b1, res(ST_OK, 8'd0, 64'd2, 1'b1)));
    // A second remove of the same slot pushes it onto the free stack twice.
    dir_rows.push_back(row(OP_REMOVE, 8'd1, '0, 1'b1, 1'b1, res(ST_OK, 8'd0, 64'd2, 1'b1)));
    dir_rows.push_back(row(OP_ADD, 8'd0, 64'hFFFF_0000_FFFF_0000, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(OP_ADD, 8'd0, 64'h0000_FFFF_0000_FFFF, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(OP_READ, 8'd1, '0, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(OP_READ, 8'd2, '0, 1'b0, 1'b1,
                           res(ST_OK, 8'd0, 64'hA5A5_5A5A_F00D_1234, 1'b1)));
    dir_rows.push_back(row(OP_REMOVE, 8'd3, '0, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(OP_REMOVE, 8'd2, '0, 1'b1, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].entry, dir_rows[i].rc,
              dir_rows[i].known, dir_rows[i].want);
    end

    // Mostly adds, then keep adding until the store is full and refuses a few.
    repeat (300) send_random(85, 10, 3);
    while (!(free_cnt == 0 && top_cnt == CAP)) send_random(100, 0, 0);
    repeat (3) send_random(100, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);

    // Removing slot 0 over and over fills the free stack until pushes are dropped.
    repeat (265) send_op(OP_REMOVE, 8'd0, {$urandom, $urandom}, 1'($urandom), 1'b0, '0);

    repeat (345) send_random(30, 25, 35);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got status %0d slot %0d",
                 $time, out_status, out_slot_out);
        $display("%0t: unexpected beat entry %h valid %0d",
                 $time, out_entry_out, out_entry_valid);
        mismatch_count++;
      end else begin
        seen_want = pending_results.pop_front();
        if (out_status !== seen_want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, seen_want.status, out_status);
          mismatch_count++;
        end
        if (out_slot_out !== seen_want.slot) begin
          $display("%0t: slot_out mismatch, expected %0d, got %0d",
                   $time, seen_want.slot, out_slot_out);
          mismatch_count++;
        end
        if (out_entry_out !== seen_want.entry) begin
          $display("%0t: entry_out mismatch, expected %h, got %h",
                   $time, seen_want.entry, out_entry_out);
          mismatch_count++;
        end
        if (out_entry_valid !== seen_want.entry_valid) begin
          $display("%0t: entry_valid mismatch, expected %0d, got %0d",
                   $time, seen_want.entry_valid, out_entry_valid);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
